@@ src/lrk4_pkg.sv @@
// ----------------------------------------------------------------------------
// lrk4_pkg: shared types, constants and microcode for the Lorenz integrator
// Holds the fixed-point formats, the channel payloads, the operation codes
// of the shared arithmetic unit and the microprogram of one Runge-Kutta step.
// ----------------------------------------------------------------------------
package lrk4_pkg;

   // Number formats
   localparam int STATE_W    = 32;
   localparam int FRAC_W     = 24;
   localparam int TIME_W     = 48;
   localparam int DT_W       = 25;
   localparam int GAIN_W     = 31;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 31;

   // Shared multiplier: two 34-bit signed operands, registered product
   localparam int MUL_W      = 34;
   localparam int PROD_W     = 2 * MUL_W;

   // Division by six: (n * ceil(2^34 / 6)) >> 34 is exact for n below 2^32
   localparam logic [STATE_W-1:0] DIV6_MAGIC = 32'hAAAA_AAAB;
   localparam int                 DIV6_SHIFT = 34;
   localparam logic [STATE_W-1:0] DIV6_BIAS  = 32'd3;

   localparam logic signed [STATE_W-1:0] STATE_MAX = {1'b0, {(STATE_W-1){1'b1}}};
   localparam logic signed [STATE_W-1:0] STATE_MIN = {1'b1, {(STATE_W-1){1'b0}}};

   // Register reset values
   localparam logic [DT_W-1:0]   STEP_SIZE_RESET = 25'd167772;
   localparam logic [GAIN_W-1:0] SIGMA_RESET     = 31'd167772160;
   localparam logic [GAIN_W-1:0] RHO_RESET       = 31'd469762048;
   localparam logic [GAIN_W-1:0] BETA_RESET      = 31'd44739243;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STEP_SIZE,
      CSR_SIGMA_GAIN,
      CSR_RHO_GAIN,
      CSR_BETA_GAIN
   } csr_index_type;

   // Item kinds
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_STEP = 1'b1;

   typedef struct packed {
      logic                      req_type;
      logic signed [STATE_W-1:0] init_x;
      logic signed [STATE_W-1:0] init_y;
      logic signed [STATE_W-1:0] init_z;
      logic signed [TIME_W-1:0]  init_time;
   } req_payload_type;

   typedef struct packed {
      logic signed [TIME_W-1:0]  time_now;
      logic signed [STATE_W-1:0] x_now;
      logic signed [STATE_W-1:0] y_now;
      logic signed [STATE_W-1:0] z_now;
      logic                      saturated;
   } rsp_payload_type;

   // Scratch register file
   localparam int RF_DEPTH = 16;
   localparam int RF_AW    = 4;

   localparam logic [RF_AW-1:0] RF_XA = 4'd0;   // evaluation point x, y, z
   localparam logic [RF_AW-1:0] RF_YA = 4'd1;
   localparam logic [RF_AW-1:0] RF_ZA = 4'd2;
   localparam logic [RF_AW-1:0] RF_SX = 4'd3;   // weighted slope sums
   localparam logic [RF_AW-1:0] RF_KX = 4'd6;   // current slopes
   localparam logic [RF_AW-1:0] RF_KZ = 4'd8;
   localparam logic [RF_AW-1:0] RF_T0 = 4'd9;   // temporaries
   localparam logic [RF_AW-1:0] RF_T1 = 4'd10;
   localparam logic [RF_AW-1:0] RF_T2 = 4'd11;

   typedef enum logic [2:0] {
      OP_ADD,
      OP_SUB,
      OP_HADD,
      OP_MUL,
      OP_DIV6
   } alu_op_type;

   typedef enum logic [2:0] {
      SRC_RF,
      SRC_X,
      SRC_Y,
      SRC_Z,
      SRC_DT,
      SRC_SIGMA,
      SRC_RHO,
      SRC_BETA
   } src_type;

   typedef enum logic [1:0] {
      DST_RF,
      DST_X,
      DST_Y,
      DST_Z
   } dst_type;

   typedef struct packed {
      alu_op_type       op;
      src_type          a_src;
      logic [RF_AW-1:0] a_addr;
      src_type          b_src;
      logic [RF_AW-1:0] b_addr;
      dst_type          dst;
      logic [RF_AW-1:0] d_addr;
   } uop_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_ISSUE,
      SEQ_EXEC,
      SEQ_FIN,
      SEQ_RESULT
   } seq_state_type;

   // Control from the sequencer to the datapath
   typedef struct packed {
      logic    idle;
      logic    mul_load;
      logic    wr_en;
      logic    rsp_load;
      uop_type uop;
   } ctl_type;

   // Microprogram layout
   localparam int PC_W     = 7;
   localparam int P_E2     = 11;
   localparam int P_K2     = 14;
   localparam int P_A2     = 25;
   localparam int P_E3     = 31;
   localparam int P_K3     = 34;
   localparam int P_A3     = 45;
   localparam int P_E4     = 51;
   localparam int P_K4     = 54;
   localparam int P_A4     = 65;
   localparam int P_FIN    = 68;
   localparam int PROG_LEN = 74;

   function automatic uop_type mk_uop(alu_op_type op, src_type a_src,
                                      logic [RF_AW-1:0] a_addr, src_type b_src,
                                      logic [RF_AW-1:0] b_addr, dst_type dst,
                                      logic [RF_AW-1:0] d_addr);
      uop_type u;
      u.op     = op;
      u.a_src  = a_src;
      u.a_addr = a_addr;
      u.b_src  = b_src;
      u.b_addr = b_addr;
      u.dst    = dst;
      u.d_addr = d_addr;
      return u;
   endfunction

   function automatic src_type coord_src(logic [1:0] c);
      src_type s;
      unique case (c)
         2'd0:    s = SRC_X;
         2'd1:    s = SRC_Y;
         default: s = SRC_Z;
      endcase
      return s;
   endfunction

   function automatic dst_type coord_dst(logic [1:0] c);
      dst_type d;
      unique case (c)
         2'd0:    d = DST_X;
         2'd1:    d = DST_Y;
         default: d = DST_Z;
      endcase
      return d;
   endfunction

   // One derivative evaluation followed by the scaling with dt.
   // The point is either the state itself or the evaluation registers.
   function automatic uop_type slope_uop(logic [3:0] idx, logic at_state,
                                         logic [RF_AW-1:0] k_base);
      src_type xs;
      src_type ys;
      src_type zs;
      uop_type u;
      if (at_state) begin
         xs = SRC_X;
         ys = SRC_Y;
         zs = SRC_Z;
      end else begin
         xs = SRC_RF;
         ys = SRC_RF;
         zs = SRC_RF;
      end
      unique case (idx)
         4'd0:  u = mk_uop(OP_SUB, ys, RF_YA, xs, RF_XA, DST_RF, RF_T0);
         4'd1:  u = mk_uop(OP_MUL, SRC_SIGMA, RF_T0, SRC_RF, RF_T0, DST_RF, RF_T0);
         4'd2:  u = mk_uop(OP_SUB, SRC_RHO, RF_T1, zs, RF_ZA, DST_RF, RF_T1);
         4'd3:  u = mk_uop(OP_MUL, xs, RF_XA, SRC_RF, RF_T1, DST_RF, RF_T1);
         4'd4:  u = mk_uop(OP_SUB, SRC_RF, RF_T1, ys, RF_YA, DST_RF, RF_T1);
         4'd5:  u = mk_uop(OP_MUL, xs, RF_XA, ys, RF_YA, DST_RF, RF_T2);
         4'd6:  u = mk_uop(OP_MUL, SRC_BETA, RF_T2, zs, RF_ZA, DST_RF, RF_KZ);
         4'd7:  u = mk_uop(OP_SUB, SRC_RF, RF_T2, SRC_RF, RF_KZ, DST_RF, RF_T2);
         4'd8:  u = mk_uop(OP_MUL, SRC_DT, RF_T0, SRC_RF, RF_T0, DST_RF, k_base);
         4'd9:  u = mk_uop(OP_MUL, SRC_DT, RF_T1, SRC_RF, RF_T1, DST_RF,
                           k_base + 4'd1);
         4'd10: u = mk_uop(OP_MUL, SRC_DT, RF_T2, SRC_RF, RF_T2, DST_RF,
                           k_base + 4'd2);
         default: u = mk_uop(OP_ADD, SRC_RF, RF_T0, SRC_RF, RF_T0, DST_RF, RF_T0);
      endcase
      return u;
   endfunction

   // Next evaluation point: state plus half or all of the given slope
   function automatic uop_type eval_uop(logic [1:0] c, logic full,
                                        logic [RF_AW-1:0] k_base);
      alu_op_type op;
      op = full ? OP_ADD : OP_HADD;
      return mk_uop(op, coord_src(c), RF_XA, SRC_RF, k_base + RF_AW'(c),
                    DST_RF, RF_XA + RF_AW'(c));
   endfunction

   // Sum += 2k, doubling first as a clipped addition of its own
   function automatic uop_type accum2_uop(logic [2:0] idx);
      logic [1:0] c;
      c = idx[2:1];
      if (!idx[0])
         return mk_uop(OP_ADD, SRC_RF, RF_KX + RF_AW'(c), SRC_RF, RF_KX + RF_AW'(c),
                       DST_RF, RF_T0);
      return mk_uop(OP_ADD, SRC_RF, RF_SX + RF_AW'(c), SRC_RF, RF_T0,
                    DST_RF, RF_SX + RF_AW'(c));
   endfunction

   function automatic uop_type accum1_uop(logic [1:0] c);
      return mk_uop(OP_ADD, SRC_RF, RF_SX + RF_AW'(c), SRC_RF, RF_KX + RF_AW'(c),
                    DST_RF, RF_SX + RF_AW'(c));
   endfunction

   // State += round(sum / 6)
   function automatic uop_type final_uop(logic [2:0] idx);
      logic [1:0] c;
      c = idx[2:1];
      if (!idx[0])
         return mk_uop(OP_DIV6, SRC_RF, RF_SX + RF_AW'(c), SRC_RF, RF_T0,
                       DST_RF, RF_T0);
      return mk_uop(OP_ADD, coord_src(c), RF_T0, SRC_RF, RF_T0, coord_dst(c), RF_T0);
   endfunction

   // Microprogram of one classical Runge-Kutta step
   function automatic uop_type uop_rom(logic [PC_W-1:0] pc);
      uop_type u;
      priority if (pc < PC_W'(P_E2))
         u = slope_uop(4'(pc), 1'b1, RF_SX);
      else if (pc < PC_W'(P_K2))
         u = eval_uop(2'(pc - PC_W'(P_E2)), 1'b0, RF_SX);
      else if (pc < PC_W'(P_A2))
         u = slope_uop(4'(pc - PC_W'(P_K2)), 1'b0, RF_KX);
      else if (pc < PC_W'(P_E3))
         u = accum2_uop(3'(pc - PC_W'(P_A2)));
      else if (pc < PC_W'(P_K3))
         u = eval_uop(2'(pc - PC_W'(P_E3)), 1'b0, RF_KX);
      else if (pc < PC_W'(P_A3))
         u = slope_uop(4'(pc - PC_W'(P_K3)), 1'b0, RF_KX);
      else if (pc < PC_W'(P_E4))
         u = accum2_uop(3'(pc - PC_W'(P_A3)));
      else if (pc < PC_W'(P_K4))
         u = eval_uop(2'(pc - PC_W'(P_E4)), 1'b1, RF_KX);
      else if (pc < PC_W'(P_A4))
         u = slope_uop(4'(pc - PC_W'(P_K4)), 1'b0, RF_KX);
      else if (pc < PC_W'(P_FIN))
         u = accum1_uop(2'(pc - PC_W'(P_A4)));
      else
         u = final_uop(3'(pc - PC_W'(P_FIN)));
      return u;
   endfunction

endpackage

@@ src/lrk4_ram.sv @@
// ----------------------------------------------------------------------------
// lrk4_ram: generic register file memory
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module lrk4_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // Storage and registered reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

@@ src/lrk4_alu.sv @@
// ----------------------------------------------------------------------------
// lrk4_alu: shared saturating arithmetic unit
// Clipped add, subtract and add-half, combinational; fixed-point multiply and
// divide-by-six through one registered multiplier, finished combinationally.
// ----------------------------------------------------------------------------
module lrk4_alu import lrk4_pkg::*; (
   input  logic                      clock,
   input  alu_op_type                op,
   input  logic                      mul_load,
   input  logic signed [STATE_W-1:0] opa,
   input  logic signed [STATE_W-1:0] opb,
   output logic signed [STATE_W-1:0] result,
   output logic                      clipped
);

   logic signed [STATE_W:0]   ext_a;
   logic signed [STATE_W:0]   ext_b;
   logic signed [STATE_W:0]   half_b;
   logic signed [STATE_W:0]   sum;
   logic signed [STATE_W-1:0] sum_res;
   logic                      sum_ovf;
   logic [STATE_W-1:0]        mag_a;
   logic [STATE_W-1:0]        div_n;
   logic signed [MUL_W-1:0]   mul_x;
   logic signed [MUL_W-1:0]   mul_y;
   logic signed [PROD_W-1:0]  prod_ff;
   logic                      neg_ff;
   logic [PROD_W-FRAC_W-STATE_W:0] prod_top;
   logic                      mul_ovf;
   logic signed [STATE_W-1:0] mul_res;
   logic [STATE_W-1:0]        quot;
   logic signed [STATE_W-1:0] div_res;

   // Add path: exact 33-bit sum, then clip to the state range
   always_comb begin
      ext_a  = {opa[STATE_W-1], opa};
      ext_b  = {opb[STATE_W-1], opb};
      half_b = {opb[STATE_W-1], opb[STATE_W-1], opb[STATE_W-1:1]};
      unique case (op)
         OP_SUB:  sum = ext_a - ext_b;
         OP_HADD: sum = ext_a + half_b;
         default: sum = ext_a + ext_b;
      endcase
      sum_ovf = sum[STATE_W] != sum[STATE_W-1];
      if (sum_ovf) begin
         sum_res = sum[STATE_W] ? STATE_MIN : STATE_MAX;
      end else begin
         sum_res = sum[STATE_W-1:0];
      end
   end

   // Multiplier operands: signed product, or rounded magnitude times 1/6
   always_comb begin
      mag_a = opa[STATE_W-1] ? (~opa + 1'b1) : opa;
      div_n = mag_a + DIV6_BIAS;
      if (op == OP_DIV6) begin
         mul_x = MUL_W'(div_n);
         mul_y = MUL_W'(DIV6_MAGIC);
      end else begin
         mul_x = MUL_W'(opa);
         mul_y = MUL_W'(opb);
      end
   end

   always_ff @(posedge clock) begin
      if (mul_load) begin
         prod_ff <= mul_x * mul_y;
         neg_ff  <= opa[STATE_W-1];
      end
   end

   // Product finish: floor shift by the fraction width, then clip
   always_comb begin
      prod_top = prod_ff[PROD_W-1:FRAC_W+STATE_W-1];
      mul_ovf  = !((&prod_top) || !(|prod_top));
      if (mul_ovf) begin
         mul_res = prod_ff[PROD_W-1] ? STATE_MIN : STATE_MAX;
      end else begin
         mul_res = prod_ff[FRAC_W+STATE_W-1:FRAC_W];
      end
      quot    = prod_ff[DIV6_SHIFT+STATE_W-1:DIV6_SHIFT];
      div_res = neg_ff ? (~quot + 1'b1) : quot;
   end

   // Result selection
   always_comb begin
      unique case (op)
         OP_ADD, OP_SUB, OP_HADD: begin
            result  = sum_res;
            clipped = sum_ovf;
         end
         OP_MUL: begin
            result  = mul_res;
            clipped = mul_ovf;
         end
         OP_DIV6: begin
            result  = div_res;
            clipped = 1'b0;
         end
         default: begin
            result  = sum_res;
            clipped = sum_ovf;
         end
      endcase
   end

endmodule

@@ src/lrk4_seq.sv @@
// ----------------------------------------------------------------------------
// lrk4_seq: microprogram sequencer
// Steps through the Runge-Kutta microprogram (add-type: issue, execute;
// multiply: issue, execute, finish) and hands the result to the output.
// ----------------------------------------------------------------------------
module lrk4_seq import lrk4_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    start_step,
   input  logic    rsp_free,
   output ctl_type ctl
);

   seq_state_type    state_ff;
   seq_state_type    state_in;
   logic [PC_W-1:0]  pc_ff;
   logic [PC_W-1:0]  pc_in;
   uop_type          uop;
   logic             is_mul;
   logic             last;

   assign uop    = uop_rom(pc_ff);
   assign is_mul = (uop.op == OP_MUL) || (uop.op == OP_DIV6);
   assign last   = pc_ff == PC_W'(PROG_LEN - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         pc_ff    <= '0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
      end
   end

   // Next state and control strobes
   always_comb begin
      state_in     = state_ff;
      pc_in        = pc_ff;
      ctl.idle     = 1'b0;
      ctl.mul_load = 1'b0;
      ctl.wr_en    = 1'b0;
      ctl.rsp_load = 1'b0;
      ctl.uop      = uop;
      unique case (state_ff)
         SEQ_IDLE: begin
            ctl.idle = 1'b1;
            if (start) begin
               pc_in    = '0;
               state_in = start_step ? SEQ_ISSUE : SEQ_RESULT;
            end
         end
         SEQ_ISSUE: begin
            state_in = SEQ_EXEC;
         end
         SEQ_EXEC: begin
            if (is_mul) begin
               ctl.mul_load = 1'b1;
               state_in     = SEQ_FIN;
            end else begin
               ctl.wr_en = 1'b1;
               if (last) begin
                  state_in = SEQ_RESULT;
               end else begin
                  pc_in    = pc_ff + 1'b1;
                  state_in = SEQ_ISSUE;
               end
            end
         end
         SEQ_FIN: begin
            ctl.wr_en = 1'b1;
            if (last) begin
               state_in = SEQ_RESULT;
            end else begin
               pc_in    = pc_ff + 1'b1;
               state_in = SEQ_ISSUE;
            end
         end
         SEQ_RESULT: begin
            if (rsp_free) begin
               ctl.rsp_load = 1'b1;
               state_in     = SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

endmodule

@@ src/lorenz_rk4_integrator.sv @@
// ----------------------------------------------------------------------------
// lorenz_rk4_integrator: fixed-point Lorenz system integrator
// Holds x, y, z (signed Q8.24) and a time value (signed Q24.24). A load item
// sets all four; a step item advances them by one fourth-order Runge-Kutta
// step of size dt. Every item returns one result item with the new values.
//
// Usage:
//  - req_valid/req_stall carry items in, rsp_valid/rsp_stall carry results
//    out; an item moves on an edge with valid high and stall low.
//  - req_stall is high from acceptance until the result has been placed in
//    the output register, so the block holds one item at a time.
//  - A load item goes from acceptance straight to the result state. A step
//    item runs 74 micro-operations on one shared unit, 43 add-type
//    operations through issue and execute and 31 multiplies through issue,
//    execute and finish on the single multiplier, then presents the result.
//  - If the receiver stalls, the result waits in the output register and a
//    new item is still accepted; its own result then waits for the register.
//  - csr_write with csr_index and csr_data sets dt, sigma, rho and beta;
//    write only while the block is idle.
//  - Reset clears the state and time to zero and restores the default
//    coefficients (dt 0.01, sigma 10, rho 28, beta eight thirds).
// ----------------------------------------------------------------------------
module lorenz_rk4_integrator import lrk4_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_payload_type       req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_data,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   ctl_type                   ctl;
   logic                      req_accept;
   logic                      rsp_free;
   logic [DT_W-1:0]           dt_ff;
   logic [GAIN_W-1:0]         sigma_ff;
   logic [GAIN_W-1:0]         rho_ff;
   logic [GAIN_W-1:0]         beta_ff;
   logic signed [STATE_W-1:0] x_ff;
   logic signed [STATE_W-1:0] y_ff;
   logic signed [STATE_W-1:0] z_ff;
   logic [TIME_W-1:0]         time_ff;
   logic                      sat_ff;
   logic                      rsp_valid_ff;
   rsp_payload_type           rsp_data_ff;
   logic [STATE_W-1:0]        rf_a;
   logic [STATE_W-1:0]        rf_b;
   logic signed [STATE_W-1:0] opa;
   logic signed [STATE_W-1:0] opb;
   logic signed [STATE_W-1:0] alu_res;
   logic                      alu_clip;
   logic                      rf_wr;

   assign req_stall  = !ctl.idle;
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   lrk4_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (req_accept),
      .start_step (req_data.req_type == REQ_STEP),
      .rsp_free   (rsp_free),
      .ctl        (ctl)
   );

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dt_ff    <= STEP_SIZE_RESET;
         sigma_ff <= SIGMA_RESET;
         rho_ff   <= RHO_RESET;
         beta_ff  <= BETA_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_STEP_SIZE:  dt_ff    <= csr_data[DT_W-1:0];
            CSR_SIGMA_GAIN: sigma_ff <= csr_data[GAIN_W-1:0];
            CSR_RHO_GAIN:   rho_ff   <= csr_data[GAIN_W-1:0];
            CSR_BETA_GAIN:  beta_ff  <= csr_data[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // Operand selection for the shared unit
   function automatic logic signed [STATE_W-1:0] pick(src_type s,
                                                       logic [STATE_W-1:0] rf);
      logic signed [STATE_W-1:0] v;
      unique case (s)
         SRC_RF:    v = rf;
         SRC_X:     v = x_ff;
         SRC_Y:     v = y_ff;
         SRC_Z:     v = z_ff;
         SRC_DT:    v = STATE_W'(dt_ff);
         SRC_SIGMA: v = STATE_W'(sigma_ff);
         SRC_RHO:   v = STATE_W'(rho_ff);
         SRC_BETA:  v = STATE_W'(beta_ff);
         default:   v = rf;
      endcase
      return v;
   endfunction

   assign opa = pick(ctl.uop.a_src, rf_a);
   assign opb = pick(ctl.uop.b_src, rf_b);

   lrk4_alu u_alu (
      .clock    (clock),
      .op       (ctl.uop.op),
      .mul_load (ctl.mul_load),
      .opa      (opa),
      .opb      (opb),
      .result   (alu_res),
      .clipped  (alu_clip)
   );

   // Scratch values of the step: evaluation point, sums, slopes, temporaries
   assign rf_wr = ctl.wr_en && (ctl.uop.dst == DST_RF);

   lrk4_ram #(
      .WIDTH (STATE_W),
      .DEPTH (RF_DEPTH)
   ) u_rf (
      .clock     (clock),
      .wr_en     (rf_wr),
      .wr_addr   (ctl.uop.d_addr),
      .wr_data   (alu_res),
      .rd_addr_a (ctl.uop.a_addr),
      .rd_addr_b (ctl.uop.b_addr),
      .rd_data_a (rf_a),
      .rd_data_b (rf_b)
   );

   // Lorenz state, time and saturation flag
   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff    <= '0;
         y_ff    <= '0;
         z_ff    <= '0;
         time_ff <= '0;
         sat_ff  <= 1'b0;
      end else if (req_accept) begin
         sat_ff <= 1'b0;
         if (req_data.req_type == REQ_LOAD) begin
            x_ff    <= req_data.init_x;
            y_ff    <= req_data.init_y;
            z_ff    <= req_data.init_z;
            time_ff <= req_data.init_time;
         end else begin
            time_ff <= time_ff + TIME_W'(dt_ff);
         end
      end else if (ctl.wr_en) begin
         sat_ff <= sat_ff | alu_clip;
         unique case (ctl.uop.dst)
            DST_X:   x_ff <= alu_res;
            DST_Y:   y_ff <= alu_res;
            DST_Z:   z_ff <= alu_res;
            default: ;
         endcase
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rsp_load) begin
         rsp_data_ff.time_now  <= time_ff;
         rsp_data_ff.x_now     <= x_ff;
         rsp_data_ff.y_now     <= y_ff;
         rsp_data_ff.z_now     <= z_ff;
         rsp_data_ff.saturated <= sat_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A result never overwrites one that the receiver is still holding off.
   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctl.rsp_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("result register loaded while a stalled result is pending");

   // A step item advances time by exactly dt.
   a_time_advance: assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_data.req_type == REQ_STEP)
      |=> time_ff == $past(time_ff) + TIME_W'($past(dt_ff)))
      else $error("time did not advance by dt on a step item");

   // The saturation flag is only raised by a write-back of the shared unit.
   a_sat_source: assert property (@(posedge clock) disable iff (reset)
      $rose(sat_ff) |-> $past(ctl.wr_en) && $past(alu_clip))
      else $error("saturation flag set without a clipped write-back");

endmodule

@@ verif/lorenz_rk4_check.sv @@
// ----------------------------------------------------------------------------
// lorenz_rk4_check: result checker for the Lorenz integrator
// Watches the register port and both item channels. It keeps its own copy of
// the coefficients, the state and the time, works out the result of every
// accepted item in Q8.24 arithmetic and compares each result item, field by
// field, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module lorenz_rk4_check import lrk4_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_payload_type       req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_payload_type       rsp_data,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    fail_count,
   output int                    pending_count,
   output int                    checked_count,
   output int                    clipped_count
);

   localparam longint FX_MAX     = longint'(STATE_MAX);
   localparam longint FX_MIN     = longint'(STATE_MIN);
   localparam int     PRINT_CAP  = 40;

   // Shadow coefficients, state and time
   longint            dt_cfg;
   longint            sigma_cfg;
   longint            rho_cfg;
   longint            beta_cfg;
   longint            pos_x;
   longint            pos_y;
   longint            pos_z;
   logic [TIME_W-1:0] elapsed;
   bit                clip_hit;

   // Predicted results, oldest first
   rsp_payload_type   trajectory_q[$];

   function automatic longint widen(input logic [STATE_W-1:0] v);
      return {{(64-STATE_W){v[STATE_W-1]}}, v};
   endfunction

   // Saturate to the state range and remember that it happened.
   function automatic longint fx_clip(input longint v);
      if (v > FX_MAX) begin
         clip_hit = 1'b1;
         return FX_MAX;
      end
      if (v < FX_MIN) begin
         clip_hit = 1'b1;
         return FX_MIN;
      end
      return v;
   endfunction

   function automatic longint fx_add(input longint a, input longint b);
      return fx_clip(a + b);
   endfunction

   function automatic longint fx_sub(input longint a, input longint b);
      return fx_clip(a - b);
   endfunction

   // Operands never exceed 32 bits, so the full product fits in 64 bits.
   // The shift truncates towards minus infinity.
   function automatic longint fx_mul(input longint a, input longint b);
      return fx_clip((a * b) >>> FRAC_W);
   endfunction

   function automatic longint fx_half(input longint v);
      return v >>> 1;
   endfunction

   // Division by six, rounding to nearest with ties away from zero
   function automatic longint fx_div6(input longint s);
      longint m;
      longint q;
      m = (s < 0) ? -s : s;
      q = (m + 3) / 6;
      return (s < 0) ? -q : q;
   endfunction

   // Lorenz derivatives at one point, each scaled by dt
   function automatic void eval_slopes(input longint x, input longint y, input longint z,
                                       output longint kx, output longint ky,
                                       output longint kz);
      longint dx;
      longint dy;
      longint dz;
      dx = fx_mul(sigma_cfg, fx_sub(y, x));
      dy = fx_sub(fx_mul(x, fx_sub(rho_cfg, z)), y);
      dz = fx_sub(fx_mul(x, y), fx_mul(beta_cfg, z));
      kx = fx_mul(dt_cfg, dx);
      ky = fx_mul(dt_cfg, dy);
      kz = fx_mul(dt_cfg, dz);
   endfunction

   // New coordinate from the four slopes: v + round((k1 + 2k2 + 2k3 + k4) / 6)
   function automatic longint fx_blend(input longint v, input longint k1, input longint k2,
                                       input longint k3, input longint k4);
      longint s;
      s = fx_add(k1, fx_add(k2, k2));
      s = fx_add(s, fx_add(k3, k3));
      s = fx_add(s, k4);
      return fx_add(v, fx_div6(s));
   endfunction

   // Apply one item to the shadow state and return the result it should give.
   function automatic rsp_payload_type integrate_item(input req_payload_type r);
      longint          a1, b1, c1;
      longint          a2, b2, c2;
      longint          a3, b3, c3;
      longint          a4, b4, c4;
      rsp_payload_type res;
      clip_hit = 1'b0;
      if (r.req_type == REQ_LOAD) begin
         pos_x   = fx_clip(widen(r.init_x));
         pos_y   = fx_clip(widen(r.init_y));
         pos_z   = fx_clip(widen(r.init_z));
         elapsed = r.init_time;
      end else begin
         eval_slopes(pos_x, pos_y, pos_z, a1, b1, c1);
         eval_slopes(fx_add(pos_x, fx_half(a1)), fx_add(pos_y, fx_half(b1)),
                     fx_add(pos_z, fx_half(c1)), a2, b2, c2);
         eval_slopes(fx_add(pos_x, fx_half(a2)), fx_add(pos_y, fx_half(b2)),
                     fx_add(pos_z, fx_half(c2)), a3, b3, c3);
         eval_slopes(fx_add(pos_x, a3), fx_add(pos_y, b3), fx_add(pos_z, c3),
                     a4, b4, c4);
         pos_x   = fx_blend(pos_x, a1, a2, a3, a4);
         pos_y   = fx_blend(pos_y, b1, b2, b3, b4);
         pos_z   = fx_blend(pos_z, c1, c2, c3, c4);
         elapsed = elapsed + dt_cfg[TIME_W-1:0];
      end
      res.time_now  = elapsed;
      res.x_now     = pos_x[STATE_W-1:0];
      res.y_now     = pos_y[STATE_W-1:0];
      res.z_now     = pos_z[STATE_W-1:0];
      res.saturated = clip_hit;
      return res;
   endfunction

   // One line per mismatch; the count keeps going once printing stops.
   task automatic report_mismatch(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
      fail_count++;
      if (fail_count <= PRINT_CAP)
         $display("MISMATCH at %0t, result %0d, %s: expected %h, got %h",
                  $time, checked_count, what, want, got);
   endtask

   // Sample both channels and the register port on every rising edge.
   always @(posedge clock) begin : monitor
      rsp_payload_type want;
      if (reset) begin
         dt_cfg        = longint'(STEP_SIZE_RESET);
         sigma_cfg     = longint'(SIGMA_RESET);
         rho_cfg       = longint'(RHO_RESET);
         beta_cfg      = longint'(BETA_RESET);
         pos_x         = 0;
         pos_y         = 0;
         pos_z         = 0;
         elapsed       = '0;
         trajectory_q.delete();
         fail_count    = 0;
         pending_count = 0;
         checked_count = 0;
         clipped_count = 0;
      end else begin
         if (csr_write) begin
            case (csr_index_type'(csr_index))
               CSR_STEP_SIZE:  dt_cfg    = {39'd0, csr_data[DT_W-1:0]};
               CSR_SIGMA_GAIN: sigma_cfg = {33'd0, csr_data[GAIN_W-1:0]};
               CSR_RHO_GAIN:   rho_cfg   = {33'd0, csr_data[GAIN_W-1:0]};
               CSR_BETA_GAIN:  beta_cfg  = {33'd0, csr_data[GAIN_W-1:0]};
               default: ;
            endcase
         end

         if (req_valid && !req_stall)
            trajectory_q.push_back(integrate_item(req_data));

         // Compare each result item with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (trajectory_q.size() == 0) begin
               report_mismatch("result with nothing predicted", '0, rsp_data.time_now);
            end else begin
               want = trajectory_q.pop_front();
               checked_count++;
               if (want.saturated)
                  clipped_count++;
               if (rsp_data.time_now !== want.time_now)
                  report_mismatch("time_now", want.time_now, rsp_data.time_now);
               if (rsp_data.x_now !== want.x_now)
                  report_mismatch("x_now", want.x_now, rsp_data.x_now);
               if (rsp_data.y_now !== want.y_now)
                  report_mismatch("y_now", want.y_now, rsp_data.y_now);
               if (rsp_data.z_now !== want.z_now)
                  report_mismatch("z_now", want.z_now, rsp_data.z_now);
               if (rsp_data.saturated !== want.saturated)
                  report_mismatch("saturated", want.saturated, rsp_data.saturated);
            end
         end

         pending_count = trajectory_q.size();
      end
   end

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the Lorenz integrator
// Drives a short directed sequence and then random load-and-step runs under a
// series of coefficient settings, from the defaults to the extremes, with the
// sender idling and the receiver stalling in several patterns. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
   import lrk4_pkg::*;

   localparam int RUN_ITEMS      = 265;
   localparam int SEGMENTS       = 7;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 200;
   localparam int SETTLE_CYCLES  = 4;

   localparam logic signed [TIME_W-1:0] TIME_LAST  = {1'b0, {(TIME_W-1){1'b1}}};
   localparam logic signed [TIME_W-1:0] TIME_FIRST = {1'b1, {(TIME_W-1){1'b0}}};

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_payload_type       req_data;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_payload_type       rsp_data;
   logic                  csr_write;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   int fail_count;
   int pending_count;
   int checked_count;
   int clipped_count;

   int send_idle_pct;
   int rsp_stall_pct;
   int loads_sent;
   int steps_sent;
   int settings_used;
   int quiet_cycles;

   lorenz_rk4_integrator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   lorenz_rk4_check trajectory_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count),
      .clipped_count (clipped_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver back-pressure, redrawn every cycle
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // Watchdog: too long without any item moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout: no item accepted for %0d cycles", WATCHDOG_LIMIT);
         $display("Regression FAIL");
         $finish;
      end
   end

   // Random coordinate; a larger shift keeps it closer to the origin.
   function automatic logic signed [STATE_W-1:0] rand_coord(input int shift);
      logic signed [STATE_W-1:0] v;
      v = $urandom;
      return v >>> shift;
   endfunction

   function automatic logic signed [TIME_W-1:0] rand_time();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[TIME_W-1:0];
   endfunction

   function automatic req_payload_type load_item(input logic signed [STATE_W-1:0] x,
                                                 input logic signed [STATE_W-1:0] y,
                                                 input logic signed [STATE_W-1:0] z,
                                                 input logic signed [TIME_W-1:0] t);
      req_payload_type p;
      p.req_type  = REQ_LOAD;
      p.init_x    = x;
      p.init_y    = y;
      p.init_z    = z;
      p.init_time = t;
      return p;
   endfunction

   // Step item; the unused fields carry noise.
   function automatic req_payload_type step_item();
      req_payload_type p;
      p.req_type  = REQ_STEP;
      p.init_x    = $urandom;
      p.init_y    = $urandom;
      p.init_z    = $urandom;
      p.init_time = rand_time();
      return p;
   endfunction

   // Present one item, idling first at random, and hold it until accepted.
   task automatic push_item(input req_payload_type p);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= p;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      @(negedge clock);
      if (p.req_type == REQ_LOAD)
         loads_sent++;
      else
         steps_sent++;
   endtask

   // Hold the sender back until every predicted result has come out.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_count != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Write all four coefficient registers while the block is idle.
   task automatic apply_settings(input logic [CSR_DATA_W-1:0] dt,
                                 input logic [CSR_DATA_W-1:0] sigma,
                                 input logic [CSR_DATA_W-1:0] rho,
                                 input logic [CSR_DATA_W-1:0] beta);
      wait_drained();
      csr_write <= 1'b1;
      csr_index <= CSR_STEP_SIZE;
      csr_data  <= dt;
      @(negedge clock);
      csr_index <= CSR_SIGMA_GAIN;
      csr_data  <= sigma;
      @(negedge clock);
      csr_index <= CSR_RHO_GAIN;
      csr_data  <= rho;
      @(negedge clock);
      csr_index <= CSR_BETA_GAIN;
      csr_data  <= beta;
      @(negedge clock);
      csr_write <= 1'b0;
      settings_used++;
   endtask

   initial begin : stimulus
      int seg;
      int sent;
      int pick;
      int n_load;
      int n_step;
      int shift;
      bit paused;

      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      csr_write     = 1'b0;
      csr_index     = '0;
      csr_data      = '0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // Directed part at the default coefficients.
      // A step straight out of reset starts from the origin at time zero.
      push_item(step_item());
      push_item(step_item());
      push_item(load_item(32'sh0100_0000, 32'sh0100_0000, 32'sh0100_0000, '0));
      repeat (3) push_item(step_item());
      // Extreme coordinates, and the time wrapping past its largest value
      push_item(load_item(STATE_MAX, STATE_MIN, STATE_MAX, TIME_LAST));
      push_item(step_item());
      push_item(load_item(STATE_MIN, STATE_MIN, STATE_MIN, TIME_FIRST));
      push_item(step_item());
      push_item(load_item('0, '0, '0, '1));
      push_item(step_item());
      push_item(load_item(STATE_MIN, STATE_MAX, STATE_MIN, '0));
      push_item(step_item());
      push_item(load_item('1, '1, '1, rand_time()));
      push_item(step_item());
      // On the plane z = rho with x = y, where the x slope starts at zero
      push_item(load_item(32'sh0800_0000, 32'sh0800_0000, 32'sh1C00_0000, '0));
      repeat (2) push_item(step_item());
      push_item(load_item(rand_coord(5), rand_coord(5), rand_coord(5), rand_time()));
      repeat (3) push_item(step_item());

      // Random part: one segment per coefficient setting
      for (seg = 0; seg < SEGMENTS; seg++) begin
         case (seg)
            0: apply_settings(CSR_DATA_W'(STEP_SIZE_RESET), SIGMA_RESET, RHO_RESET,
                              BETA_RESET);
            1: apply_settings(31'h100_0000, SIGMA_RESET, RHO_RESET, BETA_RESET);
            2: apply_settings('0, '0, '0, '0);
            3: apply_settings(CSR_DATA_W'($urandom_range(1 << 24)), '1, '1, '1);
            4: apply_settings(31'($urandom), 31'($urandom), 31'($urandom), 31'($urandom));
            5: apply_settings(CSR_DATA_W'($urandom_range(1 << 20)),
                              CSR_DATA_W'($urandom_range(20 << 24)),
                              CSR_DATA_W'($urandom_range(50 << 24)),
                              CSR_DATA_W'($urandom_range(5 << 24)));
            default: apply_settings(CSR_DATA_W'(STEP_SIZE_RESET), SIGMA_RESET, RHO_RESET,
                                    BETA_RESET);
         endcase

         // Idling pattern of this segment
         case (seg % 4)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 82;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 82;
            end
            default: begin
               send_idle_pct = 38;
               rsp_stall_pct = 38;
            end
         endcase

         sent   = 0;
         paused = 1'b0;
         while (sent < RUN_ITEMS) begin
            // Mostly a load followed by a trajectory; the rest is noise
            pick = $urandom_range(99);
            if (pick < 75) begin
               n_load = 1;
               n_step = $urandom_range(1, 24);
               shift  = $urandom_range(1, 6);
            end else if (pick < 85) begin
               n_load = 1;
               n_step = $urandom_range(1, 4);
               shift  = 0;
            end else if (pick < 93) begin
               n_load = 0;
               n_step = $urandom_range(1, 6);
               shift  = 0;
            end else begin
               n_load = $urandom_range(2, 3);
               n_step = 0;
               shift  = $urandom_range(0, 6);
            end
            repeat (n_load)
               push_item(load_item(rand_coord(shift), rand_coord(shift),
                                   rand_coord(shift), rand_time()));
            repeat (n_step)
               push_item(step_item());
            sent += n_load + n_step;

            // Halfway through, let the pipeline empty completely once
            if (!paused && sent >= RUN_ITEMS / 2) begin
               wait_drained();
               paused = 1'b1;
            end
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Covered %0d load and %0d step items over %0d coefficient settings",
               loads_sent, steps_sent, settings_used);
      $display("and four idling patterns; %0d results compared, %0d with saturation.",
               checked_count, clipped_count);
      if (fail_count == 0 && pending_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

@@ filelist.f @@
src/lrk4_pkg.sv
src/lrk4_ram.sv
src/lrk4_alu.sv
src/lrk4_seq.sv
src/lorenz_rk4_integrator.sv
verif/lorenz_rk4_check.sv
verif/tb.sv
